[hdl/tjl_fk_pkg.sv]
// Shared constants, types and arithmetic helpers for the leg forward kinematics core.
package tjl_fk_pkg;

   localparam int ANGLE_WIDTH_DEFAULT     = 16;
   localparam int TRIG_ITERATIONS_DEFAULT = 14;
   localparam int TAB_LEN                 = 20;
   localparam int CSR_INDEX_WIDTH         = 2;
   localparam int CSR_DATA_WIDTH          = 16;
   localparam int ROT_WIDTH               = 16;
   localparam int POS_WIDTH               = 19;
   localparam int CW                      = 34;
   localparam int WW                      = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIP_OFFSET   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KNEE_HEIGHT  = 2'd3;
   localparam logic [15:0] KNEE_HEIGHT_RESET = 16'd3441;

   localparam logic signed [CW-1:0] HALF_PI_Q28  = 34'sd421657428;
   localparam logic signed [CW-1:0] PI_Q28       = 34'sd843314857;
   localparam logic signed [CW-1:0] CORDIC_START = 34'sd163008218;

   typedef logic signed [CW-1:0] cordic_type;
   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [17:0]   trig_type;

   function automatic cordic_type atan_entry(input int i);
      cordic_type t;
      case (i)
         0: t = 34'sd210828714;  1: t = 34'sd124459457;  2: t = 34'sd65760959;
         3: t = 34'sd33381289;   4: t = 34'sd16755421;   5: t = 34'sd8385878;
         6: t = 34'sd4193962;    7: t = 34'sd2097109;    8: t = 34'sd1048571;
         9: t = 34'sd524287;    10: t = 34'sd262144;    11: t = 34'sd131072;
         12: t = 34'sd65536;    13: t = 34'sd32768;     14: t = 34'sd16384;
         15: t = 34'sd8192;     16: t = 34'sd4096;      17: t = 34'sd2048;
         18: t = 34'sd1024;     default: t = 34'sd512;
      endcase
      return t;
   endfunction

   function automatic wide_type rnd14(input wide_type v);
      wide_type t;
      t = v + wide_type'(8192);
      return t >>> 14;
   endfunction

   function automatic trig_type clamp_one(input wide_type v);
      trig_type r;
      if (v > wide_type'(16384)) r = 18'sd16384;
      else if (v < -wide_type'(16384)) r = -18'sd16384;
      else r = trig_type'(v);
      return r;
   endfunction

   function automatic logic signed [POS_WIDTH-1:0] clamp_pos(input wide_type v);
      logic signed [POS_WIDTH-1:0] r;
      if (v > wide_type'(262143)) r = 19'sd262143;
      else if (v < -wide_type'(262144)) r = -19'sd262144;
      else r = v[POS_WIDTH-1:0];
      return r;
   endfunction

endpackage

[hdl/tjl_fk_if.sv]
// Valid-ready channel interfaces for the leg forward kinematics core.
interface tjl_fk_req_if #(parameter int ANGLE_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [ANGLE_WIDTH-1:0] hip_abduction_angle;
   logic signed [ANGLE_WIDTH-1:0] hip_flexion_angle;
   logic signed [ANGLE_WIDTH-1:0] knee_angle;
   modport source (output valid, hip_abduction_angle, hip_flexion_angle, knee_angle,
                   input ready);
   modport sink (input valid, hip_abduction_angle, hip_flexion_angle, knee_angle,
                 output ready);
endinterface

interface tjl_fk_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
   logic signed [15:0] rot_20, rot_21, rot_22;
   logic signed [18:0] pos_x, pos_y, pos_z;
   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface

[hdl/three_joint_leg_forward_kinematics_core.sv]
// Top level: pipelined CORDIC sine/cosine and pose product for a three-joint leg.
// The pipe has TRIG_ITERATIONS + 8 register stages.
// Throughput: one request per cycle while the output is not stalled;
// the CORDIC runs one iteration per stage.
// The whole pipe advances only when the output register is free or being taken.
// Reset (synchronous, active high) clears all valid bits and loads the four registers' reset values.
module three_joint_leg_forward_kinematics_core
   import tjl_fk_pkg::*;
#(
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEFAULT,
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   tjl_fk_req_if.sink                 req,
   tjl_fk_rsp_if.source               rsp
);

   localparam int NI = TRIG_ITERATIONS;
   localparam int NS = NI + 8;

   logic [15:0] hip_ff, upper_ff, lower_ff, height_ff;
   logic [NS-1:0] vld_ff;
   logic advance;

   // output stage NS-1 holds the response
   assign advance   = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         hip_ff    <= '0;
         upper_ff  <= '0;
         lower_ff  <= '0;
         height_ff <= KNEE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HIP_OFFSET:   hip_ff    <= csr_data;
            CSR_UPPER_LENGTH: upper_ff  <= csr_data;
            CSR_LOWER_LENGTH: lower_ff  <= csr_data;
            CSR_KNEE_HEIGHT:  height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   // CORDIC stage arrays: index 0 is the fold stage output
   cordic_type x_ff [3][NI+1];
   cordic_type y_ff [3][NI+1];
   cordic_type z_ff [3][NI+1];
   logic       n_ff [3][NI+1];

   logic signed [ANGLE_WIDTH-1:0] ang [3];
   assign ang[0] = req.hip_abduction_angle;
   assign ang[1] = req.hip_flexion_angle;
   assign ang[2] = req.knee_angle;

   for (genvar j = 0; j < 3; j++) begin : g_trig
      cordic_type z0;
      assign z0 = cordic_type'(ang[j]) <<< (31 - ANGLE_WIDTH);
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[j][0] <= CORDIC_START;
            y_ff[j][0] <= '0;
            if (z0 > HALF_PI_Q28) begin
               z_ff[j][0] <= z0 - PI_Q28;
               n_ff[j][0] <= 1'b1;
            end else if (z0 < -HALF_PI_Q28) begin
               z_ff[j][0] <= z0 + PI_Q28;
               n_ff[j][0] <= 1'b1;
            end else begin
               z_ff[j][0] <= z0;
               n_ff[j][0] <= 1'b0;
            end
         end
      end
      for (genvar i = 0; i < NI; i++) begin : g_it
         always_ff @(posedge clock) begin
            if (advance) begin
               n_ff[j][i+1] <= n_ff[j][i];
               if (i < TAB_LEN && !z_ff[j][i][CW-1]) begin
                  x_ff[j][i+1] <= x_ff[j][i] - (y_ff[j][i] >>> i);
                  y_ff[j][i+1] <= y_ff[j][i] + (x_ff[j][i] >>> i);
                  z_ff[j][i+1] <= z_ff[j][i] - atan_entry(i);
               end else if (i < TAB_LEN) begin
                  x_ff[j][i+1] <= x_ff[j][i] + (y_ff[j][i] >>> i);
                  y_ff[j][i+1] <= y_ff[j][i] - (x_ff[j][i] >>> i);
                  z_ff[j][i+1] <= z_ff[j][i] + atan_entry(i);
               end else begin
                  x_ff[j][i+1] <= x_ff[j][i];
                  y_ff[j][i+1] <= y_ff[j][i];
                  z_ff[j][i+1] <= z_ff[j][i];
               end
            end
         end
      end
   end

   // stage A: round, clamp, apply fold sign
   trig_type s_ff [3], c_ff [3];
   for (genvar j = 0; j < 3; j++) begin : g_round
      wide_type xf, yf;
      assign xf = n_ff[j][NI] ? -wide_type'(x_ff[j][NI]) : wide_type'(x_ff[j][NI]);
      assign yf = n_ff[j][NI] ? -wide_type'(y_ff[j][NI]) : wide_type'(y_ff[j][NI]);
      always_ff @(posedge clock) begin
         if (advance) begin
            c_ff[j] <= clamp_one(rnd14(xf));
            s_ff[j] <= clamp_one(rnd14(yf));
         end
      end
   end

   // stage B: angle-sum products and knee position
   wide_type dl;
   assign dl = wide_type'(upper_ff) + wide_type'(lower_ff) - wide_type'(height_ff);
   wide_type c2c3_ff, s2s3_ff, s2c3_ff, c2s3_ff, s3d_ff, c3d_ff;
   trig_type s1b_ff, c1b_ff, s2b_ff, c2b_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c2c3_ff <= wide_type'(c_ff[1]) * wide_type'(c_ff[2]);
         s2s3_ff <= wide_type'(s_ff[1]) * wide_type'(s_ff[2]);
         s2c3_ff <= wide_type'(s_ff[1]) * wide_type'(c_ff[2]);
         c2s3_ff <= wide_type'(c_ff[1]) * wide_type'(s_ff[2]);
         s3d_ff  <= wide_type'(s_ff[2]) * dl;
         c3d_ff  <= wide_type'(c_ff[2]) * dl;
         s1b_ff <= s_ff[0]; c1b_ff <= c_ff[0];
         s2b_ff <= s_ff[1]; c2b_ff <= c_ff[1];
      end
   end

   // stage C: sum and round
   trig_type c23_ff, s23_ff, s1c_ff, c1c_ff, s2c_ff, c2c_ff;
   wide_type qx_ff, qz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c23_ff <= clamp_one(rnd14(c2c3_ff - s2s3_ff));
         s23_ff <= clamp_one(rnd14(s2c3_ff + c2s3_ff));
         qx_ff  <= rnd14(s3d_ff);
         qz_ff  <= wide_type'(height_ff) + rnd14(c3d_ff);
         s1c_ff <= s1b_ff; c1c_ff <= c1b_ff; s2c_ff <= s2b_ff; c2c_ff <= c2b_ff;
      end
   end

   // stage D: hip flexion products and rotation products
   wide_type m_c2qx_ff, m_s2qz_ff, m_s2qx_ff, m_c2qz_ff;
   wide_type m_s1s23_ff, m_s1c23_ff, m_c1s23_ff, m_c1c23_ff;
   trig_type s1d_ff, c1d_ff, c23d_ff, s23d_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         m_c2qx_ff <= wide_type'(c2c_ff) * qx_ff;
         m_s2qz_ff <= wide_type'(s2c_ff) * qz_ff;
         m_s2qx_ff <= wide_type'(s2c_ff) * qx_ff;
         m_c2qz_ff <= wide_type'(c2c_ff) * qz_ff;
         m_s1s23_ff <= wide_type'(s1c_ff) * wide_type'(s23_ff);
         m_s1c23_ff <= wide_type'(s1c_ff) * wide_type'(c23_ff);
         m_c1s23_ff <= wide_type'(c1c_ff) * wide_type'(s23_ff);
         m_c1c23_ff <= wide_type'(c1c_ff) * wide_type'(c23_ff);
         s1d_ff <= s1c_ff; c1d_ff <= c1c_ff; c23d_ff <= c23_ff; s23d_ff <= s23_ff;
      end
   end

   // stage E: round rotation, form r
   wide_type rx_ff, rz_ff;
   trig_type r10_ff, r12_ff, r20_ff, r22_ff, s1e_ff, c1e_ff, c23e_ff, s23e_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff  <= rnd14(m_c2qx_ff + m_s2qz_ff);
         rz_ff  <= rnd14(m_c2qz_ff - m_s2qx_ff);
         r10_ff <= clamp_one(rnd14(m_s1s23_ff));
         r12_ff <= clamp_one(rnd14(-m_s1c23_ff));
         r20_ff <= clamp_one(rnd14(-m_c1s23_ff));
         r22_ff <= clamp_one(rnd14(m_c1c23_ff));
         s1e_ff <= s1d_ff; c1e_ff <= c1d_ff; c23e_ff <= c23d_ff; s23e_ff <= s23d_ff;
      end
   end

   // stage F: hip abduction products
   wide_type m_c1ry_ff, m_s1rz_ff, m_s1ry_ff, m_c1rz_ff, rxf_ff;
   trig_type r10f_ff, r12f_ff, r20f_ff, r22f_ff, s1f_ff, c1f_ff, c23f_ff, s23f_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         m_c1ry_ff <= wide_type'(c1e_ff) * wide_type'(hip_ff);
         m_s1ry_ff <= wide_type'(s1e_ff) * wide_type'(hip_ff);
         m_s1rz_ff <= wide_type'(s1e_ff) * rz_ff;
         m_c1rz_ff <= wide_type'(c1e_ff) * rz_ff;
         rxf_ff <= rx_ff;
         r10f_ff <= r10_ff; r12f_ff <= r12_ff; r20f_ff <= r20_ff; r22f_ff <= r22_ff;
         s1f_ff <= s1e_ff; c1f_ff <= c1e_ff; c23f_ff <= c23e_ff; s23f_ff <= s23e_ff;
      end
   end

   // stage G: output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp.rot_00 <= c23f_ff[15:0];
         rsp.rot_01 <= '0;
         rsp.rot_02 <= s23f_ff[15:0];
         rsp.rot_10 <= r10f_ff[15:0];
         rsp.rot_11 <= c1f_ff[15:0];
         rsp.rot_12 <= r12f_ff[15:0];
         rsp.rot_20 <= r20f_ff[15:0];
         rsp.rot_21 <= s1f_ff[15:0];
         rsp.rot_22 <= r22f_ff[15:0];
         rsp.pos_x  <= clamp_pos(rxf_ff);
         rsp.pos_y  <= clamp_pos(rnd14(m_c1ry_ff - m_s1rz_ff));
         rsp.pos_z  <= clamp_pos(rnd14(m_s1ry_ff + m_c1rz_ff));
      end
   end

endmodule

[hdl/tjl_fk_checker.sv]
// Port-level assertions for the leg forward kinematics core, bound to the top level.
module tjl_fk_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] rot_00,
   input logic signed [15:0] rot_01,
   input logic signed [15:0] rot_11
);
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("ready while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("not ready while empty");
   a_rot01: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rot_01 == 16'sd0) else $error("rot_01 nonzero");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rot_00 <= 16'sd16384 && rot_00 >= -16'sd16384 &&
                     rot_11 <= 16'sd16384 && rot_11 >= -16'sd16384))
      else $error("rotation out of range");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind three_joint_leg_forward_kinematics_core tjl_fk_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rot_00(rsp.rot_00), .rot_01(rsp.rot_01), .rot_11(rsp.rot_11)
);

[bench/tb_top.sv]
// Testbench for the three-joint leg forward kinematics core: random angles against a pose predictor.
module tb_top
   import tjl_fk_pkg::*;
();

   typedef struct {
      logic signed [15:0] rot [9];
      logic signed [18:0] px, py, pz;
   } pose_type;

   class pose_scoreboard;
      pose_type pending [$];
      int    errors;
      logic [15:0] hip_off, upper_len, lower_len, knee_h;

      function new();
         errors = 0;
         hip_off = 0; upper_len = 0; lower_len = 0; knee_h = KNEE_HEIGHT_RESET;
      endfunction

      function longint round14(longint v);
         return (v + 8192) >>> 14;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void sin_cos(logic signed [15:0] ang, output longint s, output longint c);
         longint z, x, y, dx, dy;
         bit flip;
         longint atan_q28 [20] = '{210828714, 124459457, 65760959, 33381289, 16755421,
            8385878, 4193962, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
            16384, 8192, 4096, 2048, 1024, 512};
         z = longint'(ang) * 32768;
         flip = 0;
         x = 163008218;
         y = 0;
         if (z > 421657428) begin
            z -= 843314857; flip = 1;
         end else if (z < -421657428) begin
            z += 843314857; flip = 1;
         end
         for (int i = 0; i < 14; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q28[i];
            end else begin
               x += dx; y -= dy; z += atan_q28[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         c = clip((x + 8192) >>> 14, -16384, 16384);
         s = clip((y + 8192) >>> 14, -16384, 16384);
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_HIP_OFFSET:   hip_off = val;
            CSR_UPPER_LENGTH: upper_len = val;
            CSR_LOWER_LENGTH: lower_len = val;
            CSR_KNEE_HEIGHT:  knee_h = val;
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [15:0] a1, logic signed [15:0] a2,
                                 logic signed [15:0] a3);
         longint s1, c1, s2, c2, s3, c3, c23, s23, h, dl, qx, qy, qz, rx, ry, rz;
         longint r [9];
         pose_type p;
         sin_cos(a1, s1, c1);
         sin_cos(a2, s2, c2);
         sin_cos(a3, s3, c3);
         h = knee_h;
         dl = longint'(upper_len) + longint'(lower_len) - h;
         c23 = clip(round14(c2 * c3 - s2 * s3), -16384, 16384);
         s23 = clip(round14(s2 * c3 + c2 * s3), -16384, 16384);
         r = '{c23, 0, s23, round14(s1 * s23), c1, round14(-s1 * c23),
               round14(-c1 * s23), s1, round14(c1 * c23)};
         foreach (r[k]) p.rot[k] = 16'(clip(r[k], -16384, 16384));
         qx = round14(s3 * dl);
         qy = hip_off;
         qz = h + round14(c3 * dl);
         rx = round14(c2 * qx + s2 * qz);
         ry = qy;
         rz = round14(-s2 * qx + c2 * qz);
         p.px = 19'(clip(rx, -262144, 262143));
         p.py = 19'(clip(round14(c1 * ry - s1 * rz), -262144, 262143));
         p.pz = 19'(clip(round14(s1 * ry + c1 * rz), -262144, 262143));
         pending = {pending, p};
      endfunction

      function void check_pose(pose_type got);
         pose_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         foreach (e.rot[k])
            if (e.rot[k] !== got.rot[k]) begin
               $display("%0t: rot[%0d] expected %0d got %0d", $time, k, e.rot[k], got.rot[k]);
               errors++;
            end
         if (e.px !== got.px || e.py !== got.py || e.pz !== got.pz) begin
            $display("%0t: pos expected %0d %0d %0d got %0d %0d %0d", $time,
                     e.px, e.py, e.pz, got.px, got.py, got.pz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_HIP_OFFSET;
   logic [CSR_DATA_WIDTH-1:0] csr_data = 0;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;
   pose_scoreboard board;

   tjl_fk_req_if #(.ANGLE_WIDTH(16)) req ();
   tjl_fk_rsp_if rsp ();

   three_joint_leg_forward_kinematics_core dut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_data(csr_data), .req(req.sink), .rsp(rsp.source));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // hold off the receiver on request, else stall at random
   always @(negedge clock)
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      pose_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.rot = '{rsp.rot_00, rsp.rot_01, rsp.rot_02, rsp.rot_10, rsp.rot_11,
                     rsp.rot_12, rsp.rot_20, rsp.rot_21, rsp.rot_22};
         got.px = rsp.pos_x; got.py = rsp.pos_y; got.pz = rsp.pos_z;
         board.check_pose(got);
      end
   end

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      board.set_reg(idx, val);
   endtask

   task automatic send_request(logic signed [15:0] a1, logic signed [15:0] a2,
                               logic signed [15:0] a3);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.hip_abduction_angle <= a1;
      req.hip_flexion_angle <= a2;
      req.knee_angle <= a3;
      do @(posedge clock); while (!req.ready);
      board.note_request(a1, a2, a3);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(9))
         0: return 16'(-25736);
         1: return 16'(25736);
         2: return 16'($urandom);
         default: return 16'(int'($urandom_range(51472)) - 25736);
      endcase
   endfunction

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic random_burst(int n);
      for (int i = 0; i < n; i++) send_request(rand_angle(), rand_angle(), rand_angle());
   endtask

   initial begin
      logic signed [15:0] corner [8] = '{16'sh8000, 16'sh7fff, -16'sd25736, 16'sd25736,
         16'sd0, 16'sd12868, -16'sd12868, 16'sd12869};
      req.valid = 0;
      req.hip_abduction_angle = 0;
      req.hip_flexion_angle = 0;
      req.knee_angle = 0;
      board = new();
      repeat (5) @(negedge clock);
      reset <= 0;
      write_reg(CSR_HIP_OFFSET, 16'd1200);
      write_reg(CSR_UPPER_LENGTH, 16'd4000);
      write_reg(CSR_LOWER_LENGTH, 16'd5000);
      foreach (corner[i]) send_request(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      send_request(16'sd0, 16'sd0, 16'sd0);
      send_request(16'sd6434, 16'sd6434, 16'sd6434);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 53; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 53; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         case (ph)
            1: begin
               write_reg(CSR_HIP_OFFSET, 16'hffff);
               write_reg(CSR_UPPER_LENGTH, 16'hffff);
               write_reg(CSR_LOWER_LENGTH, 16'hffff);
               write_reg(CSR_KNEE_HEIGHT, 16'd0);
            end
            2: begin
               write_reg(CSR_HIP_OFFSET, 16'd0);
               write_reg(CSR_UPPER_LENGTH, 16'd0);
               write_reg(CSR_LOWER_LENGTH, 16'd0);
               write_reg(CSR_KNEE_HEIGHT, 16'hffff);
            end
            3, 4, 5: begin
               write_reg(CSR_HIP_OFFSET, 16'($urandom));
               write_reg(CSR_UPPER_LENGTH, 16'($urandom));
               write_reg(CSR_LOWER_LENGTH, 16'($urandom));
               write_reg(CSR_KNEE_HEIGHT, 16'($urandom));
            end
            default: ;
         endcase
         if (ph == 0) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(negedge clock);
                  hold_off = 0;
               end
               random_burst(300);
            join
         end else begin
            random_burst(300);
         end
         drain();
      end

      if (board.errors == 0)
         $display("** three_joint_leg_forward_kinematics_core: PASSED **");
      else
         $display("** three_joint_leg_forward_kinematics_core: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** three_joint_leg_forward_kinematics_core: FAILED **");
      $finish;
   end
endmodule

[three_joint_leg_forward_kinematics_core.f]
hdl/tjl_fk_pkg.sv
hdl/tjl_fk_if.sv
hdl/three_joint_leg_forward_kinematics_core.sv
hdl/tjl_fk_checker.sv
bench/tb_top.sv
